// ===== rtl/pmbus_linear_to_sdr_raw_macros.svh =====
// Assertion macros shared by the RTL of the PMBus to sensor raw converter.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef PMBUS_LINEAR_TO_SDR_RAW_MACROS_SVH
`define PMBUS_LINEAR_TO_SDR_RAW_MACROS_SVH

`ifndef SYNTH
`define PLR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PLR_NEVER(label, cond, msg) \
	`PLR_ASSERT(label, !(cond), msg)
`else
`define PLR_ASSERT(label, prop, msg)
`define PLR_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/plr_pkg.sv =====
package plr_pkg;

	localparam int NUM_W = 101;
	localparam int REM_W = 67;
	localparam int Q_W   = 16;

	localparam logic [1:0] REQ_VOLT = 2'd0;
	localparam logic [1:0] REQ_CURR = 2'd1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_MAX    = 2'd2;
	localparam logic [1:0] ST_SLOPE0 = 2'd3;

	localparam logic [1:0] CFG_SLOPE = 2'd0;
	localparam logic [1:0] CFG_OFFSET = 2'd1;
	localparam logic [1:0] CFG_EXP = 2'd2;

	localparam int OFF_BIT = 6;
	localparam logic [26:0] DEC8 = 27'd100000000;

	typedef struct packed {
		logic slope0;
		logic neg;
		logic lt;
		logic sat;
	} flags_t;

	function automatic logic [53:0] pow10(input logic [4:0] k);
		logic [53:0] r;
		case (k)
			5'd0:  r = 54'd1;
			5'd1:  r = 54'd10;
			5'd2:  r = 54'd100;
			5'd3:  r = 54'd1000;
			5'd4:  r = 54'd10000;
			5'd5:  r = 54'd100000;
			5'd6:  r = 54'd1000000;
			5'd7:  r = 54'd10000000;
			5'd8:  r = 54'd100000000;
			5'd9:  r = 54'd1000000000;
			5'd10: r = 54'd10000000000;
			5'd11: r = 54'd100000000000;
			5'd12: r = 54'd1000000000000;
			5'd13: r = 54'd10000000000000;
			5'd14: r = 54'd100000000000000;
			5'd15: r = 54'd1000000000000000;
			5'd16: r = 54'd10000000000000000;
			default: r = 54'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/plr_front.sv =====
module plr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [1:0]         req_type,
	input  logic [15:0]        reading_word,
	input  logic [7:0]         vout_mode,
	input  logic [7:0]         status_byte,
	input  logic [7:0]         slope_m,
	input  logic [7:0]         offset_b,
	input  logic [7:0]         exponent_byte,
	output logic               v_s2,
	output logic [69:0]        xp_s2,
	output logic [57:0]        yp_s2,
	output logic [4:0]         sh_s2,
	output logic [34:0]        dd_s2,
	output plr_pkg::flags_t    flags_s2
);
	import plr_pkg::*;

	logic [15:0] mant;
	logic [4:0]  e5;
	logic        neg;
	logic [4:0]  kx;
	logic [4:0]  ky;
	logic [53:0] px;
	logic [53:0] py;

	logic        v_s1;
	logic [42:0] xlo_s1;
	logic [42:0] xhi_s1;
	logic [32:0] ylo_s1;
	logic [32:0] yhi_s1;
	logic [34:0] dd_s1;
	logic [4:0]  sh_s1;
	flags_t      flags_s1;
	flags_t      fl;

	// Decode the reading into an unsigned mantissa and a binary exponent.
	always_comb begin
		neg  = 1'b0;
		mant = '0;
		e5   = '0;
		if (req_type == REQ_VOLT) begin
			mant = reading_word;
			e5   = vout_mode[4:0];
		end else if (req_type == REQ_CURR && status_byte[OFF_BIT]) begin
			mant = '0;
		end else begin
			e5 = reading_word[15:11];
			if (reading_word[10]) begin
				neg = 1'b1;
			end else begin
				mant = {6'b0, reading_word[9:0]};
			end
		end
		kx = 5'd8 - {exponent_byte[7], exponent_byte[7:4]};
		ky = 5'd8 + {exponent_byte[3], exponent_byte[3:0]};
		px = pow10(kx);
		py = pow10(ky);
		fl = '0;
		fl.slope0 = (slope_m == 8'd0);
		fl.neg = neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xlo_s1   <= 43'(mant) * 43'(px[26:0]);
			xhi_s1   <= 43'(mant) * 43'(px[53:27]);
			ylo_s1   <= 33'(offset_b) * 33'(py[24:0]);
			yhi_s1   <= 33'(offset_b) * 33'(py[49:25]);
			dd_s1    <= 35'(slope_m) * 35'(DEC8);
			// Adding 16 to a 5-bit two's complement exponent flips its top bit.
			sh_s1    <= e5 ^ 5'h10;
			flags_s1 <= fl;

			xp_s2    <= (70'(xhi_s1) << 27) + 70'(xlo_s1);
			yp_s2    <= (58'(yhi_s1) << 25) + 58'(ylo_s1);
			sh_s2    <= sh_s1;
			dd_s2    <= dd_s1;
			flags_s2 <= flags_s1;
		end
	end

endmodule

// ===== rtl/plr_align.sv =====
module plr_align (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_s2,
	input  logic [69:0]                   xp_s2,
	input  logic [57:0]                   yp_s2,
	input  logic [4:0]                    sh_s2,
	input  logic [34:0]                   dd_s2,
	input  plr_pkg::flags_t               flags_s2,
	output logic                          v_s4,
	output logic [plr_pkg::REM_W-1:0]     rem_s4,
	output logic [34:0]                   dd_s4,
	output plr_pkg::flags_t               flags_s4
);
	import plr_pkg::*;

	logic [NUM_W-1:0] x;
	logic [NUM_W-1:0] y;
	flags_t           fl3;
	flags_t           fl4;

	logic             v_s3;
	logic [NUM_W-1:0] num_s3;
	logic [34:0]      dd_s3;
	flags_t           flags_s3;

	// Both terms share the scale 2^16 * 10^8.
	always_comb begin
		x = NUM_W'(xp_s2) << sh_s2;
		y = NUM_W'({yp_s2, 16'b0});
		fl3 = flags_s2;
		fl3.lt = (x < y);
		fl4 = flags_s3;
		fl4.sat = (num_s3 >= NUM_W'({dd_s3, 32'b0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3   <= x - y;
			dd_s3    <= dd_s2;
			flags_s3 <= fl3;
			rem_s4   <= num_s3[REM_W-1:0];
			dd_s4    <= dd_s3;
			flags_s4 <= fl4;
		end
	end

endmodule

// ===== rtl/plr_div_stage.sv =====
module plr_div_stage #(
	parameter int BIT = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  logic [plr_pkg::REM_W-1:0] rem_in,
	input  logic [34:0]               dd_in,
	input  logic [15:0]               q_in,
	input  plr_pkg::flags_t           flags_in,
	output logic                      v_out,
	output logic [plr_pkg::REM_W-1:0] rem_out,
	output logic [34:0]               dd_out,
	output logic [15:0]               q_out,
	output plr_pkg::flags_t           flags_out
);
	import plr_pkg::*;

	logic [REM_W-1:0] t;
	logic             ge;
	logic [15:0]      q_nx;

	// One restoring step: the divisor carries its own 2^16 scale.
	always_comb begin
		t  = REM_W'(dd_in) << (BIT + 16);
		ge = (rem_in >= t);
		q_nx = q_in;
		q_nx[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out   <= ge ? rem_in - t : rem_in;
			dd_out    <= dd_in;
			q_out     <= q_nx;
			flags_out <= flags_in;
		end
	end

endmodule

// ===== rtl/pmbus_linear_to_sdr_raw.sv =====
// Throughput: one word per cycle unless stalled; the sixteen restoring divider stages are fully pipelined.
// A stalled output word holds the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits and sets M=1, B=0, exponents 0.
`include "pmbus_linear_to_sdr_raw_macros.svh"

module pmbus_linear_to_sdr_raw (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // reading_word[15:0], vout_mode[23:16], status_byte[31:24]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // sensor_raw[15:0]
	output logic [1:0]  m_tuser,   // conv_status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import plr_pkg::*;

	// Sensor record coefficients.
	logic [7:0] slope_m_q;
	logic [7:0] offset_b_q;
	logic [7:0] exponent_q;

	// The whole pipeline advances together whenever the output word can move.
	logic en;

	logic        v_s2;
	logic [69:0] xp_s2;
	logic [57:0] yp_s2;
	logic [4:0]  sh_s2;
	logic [34:0] dd_s2;
	flags_t      flags_s2;

	logic             v_c [0:16];
	logic [REM_W-1:0] rem_c [0:16];
	logic [34:0]      dd_c [0:16];
	logic [15:0]      q_c [0:16];
	flags_t           fl_c [0:16];

	logic        out_valid_q;
	logic [15:0] out_raw_q;
	logic [1:0]  out_status_q;
	logic [15:0] raw_nx;
	logic [1:0]  status_nx;

	assign en        = !out_valid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Writes are expected only while the pipeline is empty, so the registers
	// are read directly by the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_m_q  <= 8'd1;
			offset_b_q <= 8'd0;
			exponent_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SLOPE:  slope_m_q  <= cfg_data;
				CFG_OFFSET: offset_b_q <= cfg_data;
				CFG_EXP:    exponent_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Stages 1 and 2: decode, power-of-ten lookup and split multiplications.
	plr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.req_type      (s_tuser),
		.reading_word  (s_tdata[15:0]),
		.vout_mode     (s_tdata[23:16]),
		.status_byte   (s_tdata[31:24]),
		.slope_m       (slope_m_q),
		.offset_b      (offset_b_q),
		.exponent_byte (exponent_q),
		.v_s2          (v_s2),
		.xp_s2         (xp_s2),
		.yp_s2         (yp_s2),
		.sh_s2         (sh_s2),
		.dd_s2         (dd_s2),
		.flags_s2      (flags_s2)
	);

	// Stages 3 and 4: binary scaling, offset subtraction and overflow check.
	plr_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_s2     (v_s2),
		.xp_s2    (xp_s2),
		.yp_s2    (yp_s2),
		.sh_s2    (sh_s2),
		.dd_s2    (dd_s2),
		.flags_s2 (flags_s2),
		.v_s4     (v_c[0]),
		.rem_s4   (rem_c[0]),
		.dd_s4    (dd_c[0]),
		.flags_s4 (fl_c[0])
	);

	assign q_c[0] = '0;

	// Stages 5 to 20: one quotient bit per stage, most significant first.
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		plr_div_stage #(.BIT(Q_W - 1 - j)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.v_in      (v_c[j]),
			.rem_in    (rem_c[j]),
			.dd_in     (dd_c[j]),
			.q_in      (q_c[j]),
			.flags_in  (fl_c[j]),
			.v_out     (v_c[j+1]),
			.rem_out   (rem_c[j+1]),
			.dd_out    (dd_c[j+1]),
			.q_out     (q_c[j+1]),
			.flags_out (fl_c[j+1])
		);
	end

	// Stage 21: status priority is slope zero, then below zero, then overflow.
	always_comb begin
		if (fl_c[Q_W].slope0) begin
			raw_nx    = '0;
			status_nx = ST_SLOPE0;
		end else if (fl_c[Q_W].lt) begin
			raw_nx    = '0;
			status_nx = ST_ZERO;
		end else if (fl_c[Q_W].sat) begin
			raw_nx    = 16'hFFFF;
			status_nx = ST_MAX;
		end else begin
			raw_nx    = q_c[Q_W];
			status_nx = fl_c[Q_W].neg ? ST_ZERO : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_c[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_raw_q    <= raw_nx;
			out_status_q <= status_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_raw_q;
	assign m_tuser  = out_status_q;

	`PLR_ASSERT(a_slope0_zero, (m_tvalid && m_tuser == ST_SLOPE0) |-> (m_tdata == 16'd0), "slope zero word is not zero")
	`PLR_ASSERT(a_clamp_zero, (m_tvalid && m_tuser == ST_ZERO) |-> (m_tdata == 16'd0), "clamped word is not zero")
	`PLR_ASSERT(a_clamp_max, (m_tvalid && m_tuser == ST_MAX) |-> (m_tdata == 16'hFFFF), "overflow word is not full scale")
	`PLR_NEVER(a_stall_accept, s_tready && m_tvalid && !m_tready, "input taken while output stalls")

endmodule

// ===== tb/pmbus_linear_to_sdr_raw_test.sv =====
`timescale 1ns / 100ps

module pmbus_linear_to_sdr_raw_test;
	import plr_pkg::*;

	// Reading kinds that the package does not name.
	localparam logic [1:0] REQ_TEMP  = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// Sets the output side's long hold-off during the pressure phase.
	localparam int HOLD_CYCLES   = 400;
	// Any stretch this long with no word moving on any channel means the block hung.
	localparam int WATCHDOG_IDLE = 5000;
	localparam int ITEMS_PER_SET = 75;
	localparam int NUM_SETS      = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // reading_word[15:0], vout_mode[23:16], status_byte[31:24]
	logic [1:0]  s_tuser = '0;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // sensor_raw[15:0]
	logic [1:0]  m_tuser;        // conv_status[1:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	pmbus_linear_to_sdr_raw dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	typedef struct {
		logic [15:0] raw;
		logic [1:0]  status;
	} sensor_value_t;

	// One directed reading; the expected value is filled in only where it is obvious.
	typedef struct {
		logic [1:0]    kind;
		logic [15:0]   word;
		logic [7:0]    vmode;
		logic [7:0]    stat;
		bit            known;
		sensor_value_t value;
	} reading_row_t;

	// Our copy of the sensor record coefficients.
	logic [7:0] slope_m = 8'd1;
	logic [7:0] offset_b = 8'd0;
	logic [7:0] exponent_byte = 8'd0;

	sensor_value_t pending_values[$];
	int  mismatches = 0;
	bit  steady_flow = 1'b0;   // when set, neither side idles
	bit  hold_request = 1'b0;
	bit  stream_done = 1'b0;

	// Exact inverse linearization: everything is scaled by 2^16 * 10^8 so that the
	// comparisons and the final division work on whole numbers.
	function automatic sensor_value_t sdr_raw_of(logic [1:0] kind, logic [15:0] word,
			logic [7:0] vmode, logic [7:0] stat);
		logic [127:0]  scaled_v, scaled_b, divisor, diff;
		logic [15:0]   mant;
		logic [4:0]    e5;
		logic          negative;
		int            e, rexp, bexp;
		sensor_value_t res;
		negative = 1'b0;
		if (slope_m == 8'd0) begin
			res.raw = '0;
			res.status = ST_SLOPE0;
			return res;
		end
		if (kind == REQ_VOLT) begin
			mant = word;
			e5 = vmode[4:0];
		end else if (kind == REQ_CURR && stat[OFF_BIT]) begin
			// Output off reads as exactly zero, which is not a clamp.
			mant = '0;
			e5 = '0;
		end else begin
			e5 = word[15:11];
			negative = word[10];
			mant = negative ? 16'd0 : {6'd0, word[9:0]};
		end
		e = e5[4] ? int'(e5) - 32 : int'(e5);
		rexp = exponent_byte[7] ? int'(exponent_byte[7:4]) - 16 : int'(exponent_byte[7:4]);
		bexp = exponent_byte[3] ? int'(exponent_byte[3:0]) - 16 : int'(exponent_byte[3:0]);
		scaled_v = 128'(mant) << (e + 16);
		for (int i = 0; i < 8 - rexp; i++)
			scaled_v = scaled_v * 10;
		scaled_b = 128'(offset_b) << 16;
		for (int i = 0; i < bexp + 8; i++)
			scaled_b = scaled_b * 10;
		if (scaled_v < scaled_b) begin
			res.raw = '0;
			res.status = ST_ZERO;
			return res;
		end
		diff = scaled_v - scaled_b;
		divisor = (128'(slope_m) << 16) * 128'd100000000;
		if (diff >= (divisor << 16)) begin
			res.raw = 16'hFFFF;
			res.status = ST_MAX;
			return res;
		end
		res.raw = 16'(diff / divisor);
		res.status = negative ? ST_ZERO : ST_OK;
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 19);
		if (steady_flow || pick < 11)
			return 0;
		if (pick < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one reading and returns at the edge where it is taken.
	task automatic send_reading(logic [1:0] kind, logic [15:0] word, logic [7:0] vmode,
			logic [7:0] stat, bit known, sensor_value_t value);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {stat, vmode, word};
		do @(posedge clk); while (!s_tready);
		pending_values.push_back(known ? value : sdr_raw_of(kind, word, vmode, stat));
	endtask

	// Coefficients change only once every pending word has come back.
	task automatic write_coefficient(logic [1:0] index, logic [7:0] value);
		s_tvalid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_SLOPE:  slope_m = value;
			CFG_OFFSET: offset_b = value;
			default:    exponent_byte = value;
		endcase
	endtask

	task automatic load_record(logic [7:0] m, logic [7:0] b, logic [7:0] exps);
		write_coefficient(CFG_SLOPE, m);
		write_coefficient(CFG_OFFSET, b);
		write_coefficient(CFG_EXP, exps);
	endtask

	// Directed readings under the reset record (M=1, B=0, both exponents 0),
	// where the raw value is the decoded reading itself, clamped to 16 bits.
	reading_row_t directed_rows[] = '{
		'{REQ_VOLT,  16'h0000, 8'h00, 8'h00, 1, '{16'd0,     ST_OK}},
		'{REQ_VOLT,  16'hFFFF, 8'h00, 8'h00, 1, '{16'hFFFF,  ST_OK}},
		'{REQ_VOLT,  16'h0001, 8'h0F, 8'h00, 1, '{16'd32768, ST_OK}},
		'{REQ_VOLT,  16'h0002, 8'h0F, 8'hFF, 1, '{16'hFFFF,  ST_MAX}},
		'{REQ_VOLT,  16'hFFFF, 8'h10, 8'h00, 1, '{16'd0,     ST_OK}},
		'{REQ_VOLT,  16'hFFFF, 8'hE0, 8'h40, 1, '{16'hFFFF,  ST_OK}},
		'{REQ_VOLT,  16'h1234, 8'hFF, 8'h00, 0, '{16'd0,     ST_OK}},
		'{REQ_CURR,  16'h03FF, 8'h00, 8'h00, 1, '{16'd1023,  ST_OK}},
		'{REQ_CURR,  16'h0400, 8'h00, 8'hBF, 1, '{16'd0,     ST_ZERO}},
		'{REQ_CURR,  16'hFFFF, 8'hFF, 8'h40, 1, '{16'd0,     ST_OK}},
		'{REQ_CURR,  16'h7BFF, 8'h00, 8'h00, 1, '{16'hFFFF,  ST_MAX}},
		'{REQ_CURR,  16'hF9FF, 8'h00, 8'h00, 0, '{16'd0,     ST_OK}},
		'{REQ_TEMP,  16'h8001, 8'h00, 8'h00, 1, '{16'd0,     ST_OK}},
		'{REQ_TEMP,  16'h07FF, 8'h00, 8'h00, 1, '{16'd0,     ST_ZERO}},
		'{REQ_TEMP,  16'h0800, 8'h00, 8'h00, 1, '{16'd0,     ST_OK}},
		'{REQ_TEMP,  16'h0801, 8'h00, 8'h00, 1, '{16'd2,     ST_OK}},
		'{REQ_TEMP,  16'h4321, 8'h55, 8'h40, 0, '{16'd0,     ST_OK}},
		'{REQ_SPARE, 16'h0005, 8'h00, 8'h40, 1, '{16'd5,     ST_OK}},
		'{REQ_SPARE, 16'h0405, 8'hFF, 8'h00, 1, '{16'd0,     ST_ZERO}}
	};

	// Random reading. Most have exponents near zero and non-negative mantissas so
	// that the division path is reached; the rest are fully random words.
	task automatic send_random_reading();
		logic [1:0]    kind;
		logic [15:0]   word;
		logic [7:0]    vmode, stat;
		sensor_value_t none;
		none = '{16'd0, ST_OK};
		kind = 2'($urandom_range(0, 3));
		word = 16'($urandom);
		vmode = 8'($urandom);
		stat = 8'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			vmode[4:0] = 5'($signed($urandom_range(0, 8)) - 4);
			word[15:11] = 5'($signed($urandom_range(0, 10)) - 5);
			word[10] = 1'b0;
			stat[OFF_BIT] = ($urandom_range(0, 4) == 0);
		end
		send_reading(kind, word, vmode, stat, 0, none);
	endtask

	// Stimulus: reset, directed rows, then several coefficient sets.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_reading(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].vmode,
				directed_rows[i].stat, directed_rows[i].known, directed_rows[i].value);
		for (int set = 0; set < NUM_SETS; set++) begin
			case (set)
				0: load_record(8'd1, 8'd0, 8'h00);
				1: load_record(8'd255, 8'd255, 8'h77);
				2: load_record(8'd1, 8'd0, 8'h88);
				3: load_record(8'd0, 8'd17, 8'h12);
				4: load_record(8'd3, 8'd7, 8'hF0);
				default: load_record(8'($urandom_range(1, 255)), 8'($urandom),
					{4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
			endcase
			steady_flow = (set == 5);
			// The output side stalls for a long time while readings keep coming,
			// so the pipeline fills and the input must back up.
			if (set == 4)
				hold_request = 1'b1;
			for (int n = 0; n < ITEMS_PER_SET; n++)
				send_random_reading();
		end
		s_tvalid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		stream_done = 1'b1;
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Output side: random stalls, occasional long ones, and one very long hold-off.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = idle_cycles();
				m_tready <= (stall == 0);
			end
		end
	end

	// Every result word is checked against the oldest pending value.
	always @(posedge clk) begin
		sensor_value_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_values.size() == 0) begin
				$error("result word with nothing pending: sensor_raw=%0d conv_status=%0d",
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_values.pop_front();
				if (m_tdata !== want.raw) begin
					$error("sensor_raw: expected %0d, got %0d", want.raw, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.status) begin
					$error("conv_status: expected %0d, got %0d", want.status, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which no word moves anywhere.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_IDLE && !stream_done) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
